// ----- rtl/base2048_bit_regrouper_assert.svh -----
// Assertion macros shared by the bit regrouper RTL.
// Needs clk and rst_n in scope where used; no other dependencies.
`ifndef BASE2048_BIT_REGROUPER_ASSERT_SVH
`define BASE2048_BIT_REGROUPER_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define B2K_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled while in reset
`define B2K_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- rtl/b2k_pkg.sv -----
// Types and constants for the 8/11-bit regrouping gearbox.
// No dependencies.
package b2k_pkg;

  localparam int BYTE_BITS = 8;
  localparam int WORD_BITS = 11;
  localparam int ACC_W     = 21;  // 10 residual bits plus an 11-bit word
  localparam int CNT_W     = 5;   // holds bit counts up to 21
  localparam int RES_W     = 10;
  localparam int RCNT_W    = 4;

  // Register index, taken from paddr[2]
  localparam logic REG_DIRECTION = 1'b0;
  localparam logic REG_PAD_TAIL  = 1'b1;

  typedef struct packed {
    logic [10:0] value;
    logic        last;
  } in_item_t;

  typedef struct packed {
    logic [10:0] value_res;
    logic        last_of_item;
  } out_item_t;

  // One classified item: bits to emit and how many results it yields
  typedef struct packed {
    logic [ACC_W-1:0] acc;
    logic [CNT_W-1:0] cnt;
    logic             dir;
    logic [1:0]       nres;
    logic             pad;
  } job_t;

endpackage

// ----- rtl/b2k_front.sv -----
// Front end: appends each item to the residual store and classifies it.
// Depends on b2k_pkg and the assertion macro header.
`include "base2048_bit_regrouper_assert.svh"

module b2k_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              dir,
  input  logic              pad_tail,
  input  logic              in_push,
  output logic              in_full,
  input  b2k_pkg::in_item_t in_data,
  input  logic              q_full,
  output logic              job_push,
  output b2k_pkg::job_t     job
);

  logic [b2k_pkg::RES_W-1:0]  res_r,  res_nxt;
  logic [b2k_pkg::RCNT_W-1:0] rc_r,   rc_nxt;
  logic [b2k_pkg::ACC_W-1:0]  acc, keep_mask, keep;
  logic [b2k_pkg::CNT_W-1:0]  cnt, rem;
  logic [1:0]                 nfull;
  logic                       pad;
  logic                       accept;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;

  // Append the item and count full output groups
  always_comb begin
    if (dir) begin
      acc = {res_r, in_data.value};
      cnt = {1'b0, rc_r} + 5'd11;
      if (cnt >= 5'd16) begin
        nfull = 2'd2;
        rem   = cnt - 5'd16;
      end else if (cnt >= 5'd8) begin
        nfull = 2'd1;
        rem   = cnt - 5'd8;
      end else begin
        nfull = 2'd0;
        rem   = cnt;
      end
    end else begin
      acc = {3'b000, res_r, in_data.value[7:0]};
      cnt = {1'b0, rc_r} + 5'd8;
      if (cnt >= 5'd11) begin
        nfull = 2'd1;
        rem   = cnt - 5'd11;
      end else begin
        nfull = 2'd0;
        rem   = cnt;
      end
    end
    pad       = in_data.last && pad_tail && (rem != '0);
    keep_mask = (21'd1 << rem) - 21'd1;
    keep      = acc & keep_mask;
  end

  // Leftover bits stay right-aligned; end of message clears them
  always_comb begin
    if (in_data.last) begin
      res_nxt = '0;
      rc_nxt  = '0;
    end else begin
      res_nxt = keep[b2k_pkg::RES_W-1:0];
      rc_nxt  = rem[b2k_pkg::RCNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r <= '0;
      rc_r  <= '0;
    end else if (accept) begin
      res_r <= res_nxt;
      rc_r  <= rc_nxt;
    end
  end

  // Items that yield nothing never reach the queue
  assign job.acc  = acc;
  assign job.cnt  = cnt;
  assign job.dir  = dir;
  assign job.nres = nfull + {1'b0, pad};
  assign job.pad  = pad;
  assign job_push = accept && ((nfull != 2'd0) || pad);

  `B2K_ASSERT_IMP(a_rc_bound, 1'b1, rc_r <= 4'd10)
  `B2K_ASSERT_NEXT(a_last_clears, accept && in_data.last, rc_r == '0 && res_r == '0)

endmodule

// ----- rtl/b2k_fifo.sv -----
// Short queue of classified items between front and back end.
// Depends on b2k_pkg and the assertion macro header.
`include "base2048_bit_regrouper_assert.svh"

module b2k_fifo #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  b2k_pkg::job_t wr_data,
  output logic          full,
  input  logic          pop,
  output b2k_pkg::job_t rd_data,
  output logic          empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  b2k_pkg::job_t  mem_r [DEPTH];
  logic [AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]  cnt_r;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  `B2K_ASSERT_IMP(a_no_overflow, push, !full)

endmodule

// ----- rtl/b2k_back.sv -----
// Back end: emits head item results into the output register, one per
// cycle unless it stalls. Depends on b2k_pkg and the assertion macro header.
`include "base2048_bit_regrouper_assert.svh"

module b2k_back (
  input  logic               clk,
  input  logic               rst_n,
  input  b2k_pkg::job_t      head,
  input  logic               q_empty,
  output logic               q_pop,
  output logic               out_empty,
  input  logic               out_pop,
  output b2k_pkg::out_item_t out_data
);

  logic [1:0]                k_r,   k_nxt;
  logic [b2k_pkg::CNT_W-1:0] rem_r, rem_nxt;
  logic                      out_valid_r, out_valid_nxt;
  b2k_pkg::out_item_t        out_r, out_nxt;

  logic [b2k_pkg::CNT_W-1:0] cur_rem, ow, sh_dn, sh_up;
  logic [b2k_pkg::ACC_W-1:0] down, up, word;
  logic [1:0]                nfull;
  logic                      is_full, lst, emit;

  // Select the bits of result number k of the head item
  always_comb begin
    cur_rem = (k_r == 2'd0) ? head.cnt : rem_r;
    ow      = head.dir ? 5'd8 : 5'd11;
    nfull   = head.nres - {1'b0, head.pad};
    is_full = (k_r < nfull);
    sh_dn   = cur_rem - ow;
    sh_up   = ow - cur_rem;
    down    = head.acc >> sh_dn;
    up      = head.acc << sh_up;     // zero-padded tail
    word    = is_full ? down : up;
    lst     = (k_r == head.nres - 2'd1);
    emit    = !q_empty && (!out_valid_r || out_pop);
  end

  // Sequencing over the results of one item
  always_comb begin
    k_nxt         = k_r;
    rem_nxt       = rem_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    q_pop         = 1'b0;
    if (emit) begin
      out_nxt.value_res    = head.dir ? {3'b000, word[7:0]} : word[10:0];
      out_nxt.last_of_item = lst;
      out_valid_nxt        = 1'b1;
      if (lst) begin
        q_pop = 1'b1;
        k_nxt = 2'd0;
      end else begin
        k_nxt   = k_r + 2'd1;
        rem_nxt = sh_dn;
      end
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    out_r <= out_nxt;
  end

  assign out_empty = !out_valid_r;
  assign out_data  = out_r;

  `B2K_ASSERT_IMP(a_head_has_results, !q_empty, head.nres != 2'd0 && k_r < head.nres)
  `B2K_ASSERT_IMP(a_pop_on_emit, q_pop, !q_empty && out_valid_nxt)

endmodule

// ----- rtl/base2048_bit_regrouper.sv -----
// Bit regrouping gearbox between 8-bit bytes and 11-bit words, MSB first.
// Input queue side: in_push / in_full, item in in_data (value, last).
//   An item is taken at an edge with in_push high and in_full low.
// Result queue side: out_empty / out_pop, oldest result in out_data
//   (value_res, last_of_item); taken at an edge with out_pop high and
//   out_empty low. last_of_item marks the final result of an input item.
// Configuration: APB-style write/read port, direction at 0x0, pad_tail at
//   0x4, one bit each; write only while the block is idle. pready is tied high.
// Result path: with the queue empty and the output register free, a taken
//   item is written into the queue and its first result goes from there into
//   the output register. Items that yield nothing produce no result.
// Throughput: the back end emits one result per cycle while the receiver takes
//   them, and an item yields 0 to 3 results; the input side keeps taking
//   items until the QDEPTH-entry queue between front and back end fills.
// Reset (rst_n, synchronous, low) clears the residual bits, empties the queue and
//   the output register; direction resets to pack, pad_tail to 1.
// When the receiver stalls, the output register holds its result, the queue
//   fills, and then in_full rises until results are taken again.
// Depends on b2k_pkg, b2k_front, b2k_fifo, b2k_back.

module base2048_bit_regrouper #(
  parameter int QDEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_push,
  output logic               in_full,
  input  b2k_pkg::in_item_t  in_data,
  // result channel
  output logic               out_empty,
  input  logic               out_pop,
  output b2k_pkg::out_item_t out_data,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic          dir_r, pad_r;
  logic          cfg_wr;
  logic          q_full, q_empty, q_push, q_pop;
  b2k_pkg::job_t job, head;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r <= 1'b0;
      pad_r <= 1'b1;
    end else if (cfg_wr) begin
      case (paddr[2])
        b2k_pkg::REG_DIRECTION: dir_r <= pwdata[0];
        b2k_pkg::REG_PAD_TAIL:  pad_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      b2k_pkg::REG_DIRECTION: prdata = {31'd0, dir_r};
      b2k_pkg::REG_PAD_TAIL:  prdata = {31'd0, pad_r};
      default:                prdata = '0;
    endcase
  end

  b2k_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .dir      (dir_r),
    .pad_tail (pad_r),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_data  (in_data),
    .q_full   (q_full),
    .job_push (q_push),
    .job      (job)
  );

  b2k_fifo #(
    .DEPTH (QDEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (job),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (head),
    .empty   (q_empty)
  );

  b2k_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

// ----- test/b2k_checker.sv -----
// Scoreboard for the 8/11-bit regrouping gearbox: watches both item channels
// and the register port, predicts every result and compares it on arrival.
// Depends on b2k_pkg.
`timescale 1ns / 100ps

module b2k_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  logic               in_full,
  input  b2k_pkg::in_item_t  in_data,
  input  logic               out_empty,
  input  logic               out_pop,
  input  b2k_pkg::out_item_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  input  logic               end_check,
  output int                 errors,
  output int                 outstanding,
  output int                 checked
);

  // Shadow of the block's registers and residual store
  logic        dir_sel;
  logic        pad_on;
  logic [9:0]  held_bits;
  logic [3:0]  held_count;

  b2k_pkg::out_item_t regrouped_q [$];
  b2k_pkg::out_item_t want;

  initial begin
    errors      = 0;
    checked     = 0;
    outstanding = 0;
  end

  function automatic logic [31:0] low_bits(input int w);
    return (32'd1 << w) - 32'd1;
  endfunction

  task automatic report(input string msg);
    if (errors < 100) $display("[%0t] mismatch: %s", $realtime, msg);
    errors++;
  endtask

  // Append one input item to the residual store and queue what falls out
  task automatic regroup(input logic [10:0] v, input logic l);
    logic [31:0]        acc;
    int                 cnt;
    int                 in_w;
    int                 out_w;
    int                 n;
    b2k_pkg::out_item_t res [3];
    in_w  = dir_sel ? b2k_pkg::WORD_BITS : b2k_pkg::BYTE_BITS;
    out_w = dir_sel ? b2k_pkg::BYTE_BITS : b2k_pkg::WORD_BITS;
    acc   = dir_sel ? {21'b0, v} : {24'b0, v[7:0]};   // bits 10..8 unused when packing
    acc   = acc | ({22'b0, held_bits} << in_w);
    cnt   = held_count + in_w;
    n     = 0;
    while (cnt >= out_w && n < 3) begin
      cnt -= out_w;
      res[n].value_res    = 11'((acc >> cnt) & low_bits(out_w));
      res[n].last_of_item = 1'b0;
      n++;
    end
    if (l) begin
      // message end: left-align leftover and pad with zeros, or drop it
      if (pad_on && cnt != 0 && n < 3) begin
        res[n].value_res    = 11'(((acc & low_bits(cnt)) << (out_w - cnt)) & low_bits(out_w));
        res[n].last_of_item = 1'b0;
        n++;
      end
      held_bits  = '0;
      held_count = '0;
    end else begin
      held_bits  = 10'(acc & low_bits(cnt));
      held_count = 4'(cnt);
    end
    for (int k = 0; k < n; k++) begin
      if (k == n - 1) res[k].last_of_item = 1'b1;
      regrouped_q.push_back(res[k]);
    end
  endtask

  // Sample all channels at the clock edge
  always @(posedge clk) begin
    if (!rst_n) begin
      regrouped_q.delete();
      held_bits  = '0;
      held_count = '0;
      dir_sel    = 1'b0;
      pad_on     = 1'b1;
    end else begin
      // results first: none can stem from an item taken at the same edge
      if (out_pop && !out_empty) begin
        checked++;
        if (regrouped_q.size() == 0) begin
          report($sformatf("unexpected result value=%h last=%b",
                           out_data.value_res, out_data.last_of_item));
        end else begin
          want = regrouped_q.pop_front();
          if (out_data.value_res !== want.value_res ||
              out_data.last_of_item !== want.last_of_item)
            report($sformatf("value got %h want %h, last got %b want %b",
                             out_data.value_res, want.value_res,
                             out_data.last_of_item, want.last_of_item));
        end
      end
      if (in_push && !in_full) regroup(in_data.value, in_data.last);
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == b2k_pkg::REG_DIRECTION) dir_sel = pwdata[0];
        else                                    pad_on  = pwdata[0];
      end
      if (end_check && regrouped_q.size() != 0)
        report($sformatf("%0d expected results never arrived", regrouped_q.size()));
    end
    outstanding <= regrouped_q.size();
  end

endmodule

// ----- test/tb.sv -----
// Top of the gearbox testbench: clock, reset, stimulus and verdict.
// Depends on b2k_pkg, base2048_bit_regrouper and b2k_checker.
`timescale 1ns / 100ps

module tb;

  logic               clk;
  logic               rst_n;
  logic               in_push;
  logic               in_full;
  b2k_pkg::in_item_t  in_data;
  logic               out_empty;
  logic               out_pop;
  b2k_pkg::out_item_t out_data;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               end_check;

  int errors;
  int outstanding;
  int checked;
  int sent;
  int msg_left;
  int waited;
  int settings;

  // stimulus knobs shared with the receiver process
  bit gaps_on;
  bit stalls_on;
  bit hold_req;

  base2048_bit_regrouper DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  b2k_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_data     (in_data),
    .out_empty   (out_empty),
    .out_pop     (out_pop),
    .out_data    (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .end_check   (end_check),
    .errors      (errors),
    .outstanding (outstanding),
    .checked     (checked)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Run limit
  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

  // Receiver: random stall bursts, plus one long hold-off on request
  initial begin : receiver
    int stall_left;
    int hold_left;
    bit pop_next;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop_next = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        pop_next = 1'b0;
      end else if (stalls_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 12) - 1;
        pop_next   = 1'b0;
      end else begin
        pop_next = 1'b1;
      end
      out_pop <= pop_next;
    end
  end

  // Offer one item, with an optional idle burst ahead of it
  task automatic send_item(input logic [10:0] v, input logic l);
    b2k_pkg::in_item_t it;
    it.value = v;
    it.last  = l;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_data <= it;
    in_push <= 1'b1;
    @(posedge clk);
    while (in_full) @(posedge clk);
    sent++;
  endtask

  // Stop offering and wait until every expected result has been taken
  task automatic drain_results();
    in_push <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Setup and access phases, then the port returns to idle
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Registers change only once the block is idle; items with no result
  // may still be in flight, hence the extra cycles
  task automatic configure(input logic dir, input logic pad);
    drain_results();
    repeat (10) @(posedge clk);
    write_reg({b2k_pkg::REG_DIRECTION, 2'b00}, {31'b0, dir});
    write_reg({b2k_pkg::REG_PAD_TAIL, 2'b00}, {31'b0, pad});
    settings++;
  endtask

  // Random messages of random length, with the odd stray or missing last flag
  task automatic random_run(input int count);
    logic l;
    for (int i = 0; i < count; i++) begin
      if (msg_left == 0)
        msg_left = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 6);
      msg_left--;
      l = (msg_left == 0);
      if ($urandom_range(0, 11) == 0) l = ~l;
      send_item(11'($urandom_range(0, 2047)), l);
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_push   = 1'b0;
    in_data   = '0;
    out_pop   = 1'b0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    end_check = 1'b0;
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    hold_req  = 1'b0;
    sent      = 0;
    msg_left  = 0;
    settings  = 1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset settings (pack, pad on); four bytes leave ten bits,
    // padded into a third word; upper bits of the bytes must be ignored
    send_item(11'h000, 1'b0);
    send_item(11'h7FF, 1'b0);
    send_item(11'h5A5, 1'b0);
    send_item(11'h0FF, 1'b1);
    // five bits left pending, then direction flips mid-message
    send_item(11'h123, 1'b0);
    send_item(11'h3C3, 1'b0);
    configure(1'b1, 1'b1);
    // 5 + 11 bits give two bytes and nothing left at message end
    send_item(11'h555, 1'b1);
    send_item(11'h7FF, 1'b0);
    send_item(11'h000, 1'b0);
    send_item(11'h001, 1'b1);
    send_item(11'h400, 1'b1);
    // ten pending bits carried into unpack: three results from one word
    configure(1'b0, 1'b1);
    send_item(11'h080, 1'b0);
    send_item(11'h0FE, 1'b0);
    send_item(11'h001, 1'b0);
    send_item(11'h77F, 1'b0);
    configure(1'b1, 1'b1);
    send_item(11'h7FF, 1'b1);
    // padding off: leftovers dropped, a last byte alone yields nothing
    configure(1'b1, 1'b0);
    send_item(11'h2AB, 1'b0);
    send_item(11'h154, 1'b1);
    send_item(11'h7FF, 1'b1);
    configure(1'b0, 1'b0);
    send_item(11'h0C3, 1'b1);
    send_item(11'h0FF, 1'b0);
    send_item(11'h0FF, 1'b0);
    send_item(11'h0FF, 1'b1);

    // Random: pack with padding, including a long receiver hold-off
    configure(1'b0, 1'b1);
    random_run(20);
    hold_req = 1'b1;
    gaps_on  = 1'b0;
    random_run(25);
    gaps_on  = 1'b1;
    random_run(10);

    // unpack, padding off, with a full pause of the sender midway
    configure(1'b1, 1'b0);
    random_run(25);
    drain_results();
    random_run(25);

    configure(1'b1, 1'b1);
    random_run(50);

    configure(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    random_run(30);

    // last stretch without idling on either side
    configure(1'b0, 1'b0);
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    random_run(35);
    in_push <= 1'b0;

    // wait for the tail, with a bound
    waited = 0;
    @(posedge clk);
    while (outstanding != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    end_check <= 1'b1;
    @(posedge clk);
    end_check <= 1'b0;
    repeat (2) @(posedge clk);

    $display("summary: %0d items sent under %0d register settings, %0d results compared",
             sent, settings, checked);
    $display("summary: pack and unpack, padding on and off, direction changes mid-message");
    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
